>>> rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge while reset is released.
`define RBQ_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rbq assertion failed");

// Checks that a trigger is followed by a consequence on the next clock edge.
`define RBQ_ASSERT_NEXT(label, trig, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error("rbq assertion failed");

`endif

>>> rtl/rbq_pkg.sv
// Package with the types, codes and defaults of the double-ended ring buffer queue.
package rbq_pkg;

  // Default sizes of the entry memory.
  localparam int unsigned DefDepth     = 16;
  localparam int unsigned DefDataWidth = 32;

  // Fixed widths of the transfer fields.
  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 5;

  // Operation codes.
  typedef enum logic [1:0] {
    FUNC_PUSH_BACK  = 2'd0,
    FUNC_PUSH_FRONT = 2'd1,
    FUNC_POP_FRONT  = 2'd2,
    FUNC_STATUS     = 2'd3
  } func_e;

  // Status codes returned with every result.
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // One command transfer.
  typedef struct packed {
    func_e                     func;
    logic signed [ValueW-1:0]  data_value;
  } req_t;

  // One result transfer.
  typedef struct packed {
    logic signed [ValueW-1:0]  front_value;
    logic        [CountW-1:0]  held_count;
    status_e                   status;
  } rsp_t;

endpackage

>>> rtl/ring_buffer_queue_push_both_ends_core.sv
// Double-ended queue of signed words kept in a ring buffer memory.
//
//   Channel   Handshake          Payload   Direction
//   command   start_i / busy_o   req_i     in
//   result    done_o (strobe)    rsp_o     out
//
// One command transfer per clock cycle; busy_o stays low.
// The result of a command appears on rsp_o with done_o in the cycle after its transfer.
// The figure is set by the entry memory, which takes one write and one read per cycle.
// Reset clears the head index and the word count; the entry memory is not cleared.
// The receiver cannot stall, so no result is held back.
module ring_buffer_queue_push_both_ends_core #(
  parameter int unsigned DEPTH      = rbq_pkg::DefDepth,
  parameter int unsigned DATA_WIDTH = rbq_pkg::DefDataWidth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  rbq_pkg::req_t req_i,
  output logic         busy_o,
  output logic         done_o,
  output rbq_pkg::rsp_t rsp_o
);
  import rbq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // Control state.
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          done_q;

  // Result payload and entry memory.
  logic [DATA_WIDTH-1:0] entry_mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_q;
  logic [DATA_WIDTH-1:0] wdata_q;
  logic                  fwd_q;
  status_e               status_q;

  logic                  accept;
  logic                  full;
  logic                  empty;
  logic [AW-1:0]         head_inc;
  logic [AW-1:0]         head_dec;
  logic [CW:0]           tail_sum;
  logic [AW-1:0]         tail;
  logic [DATA_WIDTH-1:0] wdata;
  logic                  we;
  logic [AW-1:0]         waddr;
  logic                  fwd;
  status_e               status_d;
  logic [DATA_WIDTH-1:0] front_word;

  // The block never stalls a command.
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // Ring index arithmetic.
  assign full     = (cnt_q == CW'(DEPTH));
  assign empty    = (cnt_q == '0);
  assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - 1'b1;
  assign tail_sum = (CW+1)'(head_q) + (CW+1)'(cnt_q);
  assign tail     = (tail_sum >= (CW+1)'(DEPTH)) ? AW'(tail_sum - (CW+1)'(DEPTH))
                                                  : AW'(tail_sum);
  assign wdata    = DATA_WIDTH'(req_i.data_value);

  // Decode the operation into a memory write and new index and count.
  always_comb begin
    head_d   = head_q;
    cnt_d    = cnt_q;
    we       = 1'b0;
    waddr    = tail;
    status_d = ST_DONE;
    unique case (req_i.func)
      FUNC_PUSH_BACK: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          we    = 1'b1;
          waddr = tail;
          cnt_d = cnt_q + 1'b1;
        end
      end
      FUNC_PUSH_FRONT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          we     = 1'b1;
          waddr  = head_dec;
          head_d = head_dec;
          cnt_d  = cnt_q + 1'b1;
        end
      end
      FUNC_POP_FRONT: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          head_d = head_inc;
          cnt_d  = cnt_q - 1'b1;
        end
      end
      FUNC_STATUS: begin
      end
    endcase
  end

  // When the new front entry is the one being written in the same cycle, forward it.
  assign fwd = we && (waddr == head_d);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        head_q <= head_d;
        cnt_q  <= cnt_d;
      end
    end
  end

  // Result payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      fwd_q    <= fwd;
      wdata_q  <= wdata;
    end
  end

  // Entry memory: one write and one registered read of the new front entry.
  always_ff @(posedge clk_i) begin
    if (accept && we) begin
      entry_mem[waddr] <= wdata;
    end
    if (accept) begin
      rd_q <= entry_mem[head_d];
    end
  end

  // Result assembly.
  assign front_word        = fwd_q ? wdata_q : rd_q;
  assign done_o            = done_q;
  assign rsp_o.front_value = (cnt_q == '0) ? '0 : ValueW'(signed'(front_word));
  assign rsp_o.held_count  = CountW'(cnt_q);
  assign rsp_o.status      = status_q;

endmodule

>>> rtl/rbq_checker.sv
// Port checker for the double-ended ring buffer queue, bound to its top level.
`include "assert_macros.svh"

module rbq_checker #(
  parameter int unsigned DEPTH = rbq_pkg::DefDepth
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start_i,
  input logic          busy_o,
  input logic          done_o,
  input rbq_pkg::rsp_t rsp_o
);
  import rbq_pkg::*;

  logic empty_ok;
  logic full_ok;

  // Result fields expected with each refusal.
  assign empty_ok = (rsp_o.held_count == '0) && (rsp_o.front_value == '0);
  assign full_ok  = (rsp_o.held_count == CountW'(DEPTH));

  // Every command transfer yields exactly one result in the next cycle.
  `RBQ_ASSERT_NEXT(a_result_follows, start_i && !busy_o, done_o)
  `RBQ_ASSERT_NEXT(a_no_spurious_result, !(start_i && !busy_o), !done_o)

  // A refused pop leaves an empty queue with a zero front word.
  `RBQ_ASSERT(a_empty_result, done_o && rsp_o.status == ST_EMPTY |-> empty_ok)

  // A refused push only happens when the queue holds all entries.
  `RBQ_ASSERT(a_full_result, done_o && rsp_o.status == ST_FULL |-> full_ok)

endmodule

bind ring_buffer_queue_push_both_ends_core rbq_checker #(.DEPTH(DEPTH)) u_rbq_checker (.*);

>>> verif/tb_top.sv
// Self-checking testbench of the double-ended ring buffer queue core.
`timescale 1ns / 1ps

module tb_top;
  import rbq_pkg::*;

  localparam int unsigned Depth  = DefDepth;
  localparam int unsigned DataW  = DefDataWidth;
  localparam int unsigned IdxW   = $clog2(Depth);
  localparam int unsigned NumRnd = 1700;

  // One queued command and whether the sender first waits for all results.
  typedef struct {
    req_t cmd;
    bit   drain_first;
  } backlog_t;

  logic  clk_i   = 1'b0;
  logic  rst_ni  = 1'b0;
  logic  start_i = 1'b0;
  req_t  req_i   = '0;
  logic  busy_o;
  logic  done_o;
  rsp_t  rsp_o;

  backlog_t cmd_backlog[$];
  rsp_t     deque_answers[$];
  int unsigned cmds_total;
  int unsigned cmds_taken   = 0;
  int unsigned mismatch_cnt = 0;
  bit          took_cmd     = 1'b0;

  // Shadow copy of the queue contents.
  logic signed [DataW-1:0] ring_words [Depth];
  logic [IdxW-1:0]         head_idx = '0;
  logic [CountW-1:0]       word_cnt = '0;

  ring_buffer_queue_push_both_ends_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .req_i   (req_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .rsp_o   (rsp_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Applies one command to the shadow queue and returns the answer it earns.
  function automatic rsp_t apply_deque_op(req_t cmd);
    rsp_t            res;
    status_e         st;
    logic [IdxW-1:0] slot;
    st = ST_DONE;
    case (cmd.func)
      FUNC_PUSH_BACK: begin
        if (word_cnt == Depth) begin
          st = ST_FULL;
        end else begin
          slot = head_idx + word_cnt[IdxW-1:0];
          ring_words[slot] = cmd.data_value[DataW-1:0];
          word_cnt++;
        end
      end
      FUNC_PUSH_FRONT: begin
        if (word_cnt == Depth) begin
          st = ST_FULL;
        end else begin
          head_idx = head_idx - 1'b1;
          ring_words[head_idx] = cmd.data_value[DataW-1:0];
          word_cnt++;
        end
      end
      FUNC_POP_FRONT: begin
        if (word_cnt == 0) begin
          st = ST_EMPTY;
        end else begin
          head_idx = head_idx + 1'b1;
          word_cnt--;
        end
      end
      default: ;
    endcase
    // Only the front entry is read, and only while something is held.
    if (word_cnt == 0) begin
      res.front_value = '0;
    end else begin
      res.front_value = ring_words[head_idx];
    end
    res.held_count = word_cnt;
    res.status     = st;
    return res;
  endfunction

  // Random word, with the extremes and the small values turning up often.
  function automatic logic signed [ValueW-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return ($urandom_range(1)) ? 32'sh0 : -32'sh1;
      default: return $urandom();
    endcase
  endfunction

  task automatic add_cmd(func_e op, logic signed [ValueW-1:0] val, bit drain);
    backlog_t item;
    item.cmd.func       = op;
    item.cmd.data_value = val;
    item.drain_first    = drain;
    cmd_backlog.push_back(item);
  endtask

  // Sender: presents a new command after each transfer, idling at random
  // except in one quiet stretch, and holding back where a drain is asked.
  always @(negedge clk_i) begin : drive
    bit       hold;
    bit       quiet;
    req_t     junk;
    backlog_t nxt;
    if (rst_ni && (!start_i || took_cmd)) begin
      quiet = (cmds_taken >= 700 && cmds_taken < 1000);
      hold  = (cmd_backlog.size() == 0) || (!quiet && $urandom_range(99) < 21);
      if (!hold && cmd_backlog[0].drain_first && deque_answers.size() != 0) begin
        hold = 1'b1;
      end
      if (hold) begin
        junk.func       = func_e'($urandom_range(3));
        junk.data_value = $urandom();
        start_i <= 1'b0;
        req_i   <= junk;
      end else begin
        nxt = cmd_backlog.pop_front();
        start_i <= 1'b1;
        req_i   <= nxt.cmd;
      end
    end
  end

  // Results are checked against the oldest answer, then the transfer of this
  // edge, if any, is predicted.
  always @(posedge clk_i) begin : watch
    rsp_t want;
    if (!rst_ni) begin
      took_cmd = 1'b0;
    end else begin
      if (done_o) begin
        if (deque_answers.size() == 0) begin
          $display("%0t: unexpected result front %0d count %0d status %0d",
                   $time, rsp_o.front_value, rsp_o.held_count, rsp_o.status);
          mismatch_cnt++;
        end else begin
          want = deque_answers.pop_front();
          if (rsp_o.front_value !== want.front_value) begin
            $display("%0t: front_value expected %0d actual %0d",
                     $time, want.front_value, rsp_o.front_value);
            mismatch_cnt++;
          end
          if (rsp_o.held_count !== want.held_count) begin
            $display("%0t: held_count expected %0d actual %0d",
                     $time, want.held_count, rsp_o.held_count);
            mismatch_cnt++;
          end
          if (rsp_o.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d",
                     $time, want.status, rsp_o.status);
            mismatch_cnt++;
          end
        end
      end
      took_cmd = start_i && !busy_o;
      if (took_cmd) begin
        deque_answers.push_back(apply_deque_op(req_i));
        cmds_taken++;
      end
    end
  end

  // Reset sequence.
  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // Runaway guard.
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Stimulus and end of run.
  initial begin : stimulus
    int unsigned mode;
    int unsigned len;
    int unsigned roll;
    int unsigned n;
    func_e       op;

    // Directed: empty cases, extremes, filling to full and refusals.
    add_cmd(FUNC_STATUS, 32'sh1234_5678, 1'b0);
    add_cmd(FUNC_POP_FRONT, -32'sh1, 1'b0);
    add_cmd(FUNC_PUSH_BACK, 32'sh7fff_ffff, 1'b0);
    add_cmd(FUNC_PUSH_FRONT, 32'sh8000_0000, 1'b0);
    add_cmd(FUNC_POP_FRONT, 32'sh0, 1'b0);
    add_cmd(FUNC_STATUS, 32'sh0, 1'b0);
    for (int i = 0; i < 15; i++) begin
      case (i % 4)
        0: add_cmd(FUNC_PUSH_FRONT, 32'sh5555_5555, 1'b0);
        1: add_cmd(FUNC_PUSH_BACK, 32'shaaaa_aaaa, 1'b0);
        2: add_cmd(FUNC_PUSH_FRONT, -32'sh1, 1'b0);
        default: add_cmd(FUNC_PUSH_BACK, 32'sh1, 1'b0);
      endcase
    end
    add_cmd(FUNC_PUSH_BACK, 32'sh0bad_cafe, 1'b0);
    add_cmd(FUNC_PUSH_FRONT, 32'sh0bad_cafe, 1'b0);
    add_cmd(FUNC_STATUS, 32'sh0, 1'b0);
    add_cmd(FUNC_POP_FRONT, 32'sh0, 1'b0);

    // Random: runs that lean toward filling, draining or neither, so that the
    // queue often reaches full and empty and the head wraps both ways.
    n = 0;
    while (n < NumRnd) begin
      mode = $urandom_range(2);
      len  = $urandom_range(10, 60);
      for (int i = 0; i < len; i++) begin
        roll = $urandom_range(99);
        case (mode)
          0: op = (roll < 75) ? (roll < 38 ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT)
                  : (roll < 95) ? FUNC_POP_FRONT : FUNC_STATUS;
          1: op = (roll < 70) ? FUNC_POP_FRONT
                  : (roll < 95) ? (roll < 83 ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT)
                  : FUNC_STATUS;
          default: op = func_e'($urandom_range(3));
        endcase
        add_cmd(op, pick_value(), (n == 0 || n == 900));
        n++;
      end
    end
    cmds_total = cmd_backlog.size();

    while (cmds_taken != cmds_total || deque_answers.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
